// ===== sv/mmng8_pkg.sv =====
// ----------------------------------------------------------------------------
// mmng8_pkg: shared types and constants of the min/max gray8 normalizer
// Item structs, divider request/response and the width constants.
// ----------------------------------------------------------------------------
`default_nettype none

package mmng8_pkg;

  localparam int SampleBits = 16;
  localparam int GrayBits   = 8;
  // dividend 2*(x*255)+d stays below 511*2^SampleBits
  localparam int NumW       = SampleBits + 9;
  // divisor 2*d
  localparam int DenW       = SampleBits + 1;
  localparam int DivSteps   = GrayBits;
  localparam int CntW       = $clog2(DivSteps);

  localparam logic KindScan = 1'b0;
  localparam logic KindNorm = 1'b1;

  typedef struct packed {
    logic                         kind;
    logic signed [SampleBits-1:0] sample;
    logic                         first;
  } in_item_t;

  typedef struct packed {
    logic [GrayBits-1:0] gray;
    logic                flat;
  } out_item_t;

  typedef struct packed {
    logic            start;
    logic [NumW-1:0] num;
    logic [DenW-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic                done;
    logic [GrayBits-1:0] quot;
  } div_rsp_t;

endpackage

`default_nettype wire

// ===== sv/mmng8_div.sv =====
// ----------------------------------------------------------------------------
// mmng8_div: radix-2 restoring divider
// One quotient bit per cycle; the quotient is known to fit in GrayBits.
// ----------------------------------------------------------------------------
`default_nettype none

module mmng8_div (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  mmng8_pkg::div_req_t     req_i,
  output mmng8_pkg::div_rsp_t     rsp_o
);

  logic                               busy_q;
  logic [mmng8_pkg::CntW-1:0]         cnt_q;
  logic [mmng8_pkg::NumW-1:0]         rem_q;
  logic [mmng8_pkg::NumW-1:0]         dsh_q;
  logic [mmng8_pkg::GrayBits-1:0]     quo_q;
  logic [mmng8_pkg::NumW:0]           trial;
  logic                               ge;

  assign trial = {1'b0, rem_q} - {1'b0, dsh_q};
  assign ge    = ~trial[mmng8_pkg::NumW];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (req_i.start) begin
      busy_q <= 1'b1;
      cnt_q  <= mmng8_pkg::CntW'(mmng8_pkg::DivSteps - 1);
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= req_i.num;
      // divisor aligned to the top quotient bit
      dsh_q <= mmng8_pkg::NumW'(req_i.den) << (mmng8_pkg::DivSteps - 1);
      quo_q <= '0;
    end else if (busy_q) begin
      if (ge) begin
        rem_q <= trial[mmng8_pkg::NumW-1:0];
      end
      dsh_q <= dsh_q >> 1;
      quo_q <= {quo_q[mmng8_pkg::GrayBits-2:0], ge};
    end
  end

  assign rsp_o.done = busy_q && (cnt_q == '0);
  assign rsp_o.quot = {quo_q[mmng8_pkg::GrayBits-2:0], ge};

endmodule

`default_nettype wire

// ===== sv/min_max_normalize_to_gray8_core.sv =====
// ----------------------------------------------------------------------------
// min_max_normalize_to_gray8_core: two-pass contrast stretch to 8-bit gray
// Tracks the frame min/max and maps samples to round((s-min)*255/(max-min)).
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid_i / in_stall_o / in_data_i carries items. A scan
//   item (kind 0) updates the running min/max in the cycle it is taken and
//   gives no result; first restarts both at that sample. A normalize item
//   (kind 1) gives one result on out_valid_o / out_stall_i / out_data_o.
//   A scan item never raises in_stall_o. A normalize item passes through
//   prep, multiply, 8 radix-2 divider steps and load before out_valid_o
//   rises; samples at or outside the range, or a flat frame, go from prep
//   straight to load. The block holds in_stall_o high while an item is in
//   work, so one item is in work at a time and the next is taken in the
//   cycle after the load. The result sits in an output register; a new
//   item is taken while it waits. A finished item waits in the core if
//   that register is still stalled. Reset clears min/max to zero and
//   empties the output.
//   A flat frame (max equals min) gives gray 0 with flat set.
// ----------------------------------------------------------------------------
`default_nettype none

module min_max_normalize_to_gray8_core (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  mmng8_pkg::in_item_t       in_data_i,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output mmng8_pkg::out_item_t      out_data_o
);

  localparam int SB = mmng8_pkg::SampleBits;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_PREP = 5'b00010,
    ST_MUL  = 5'b00100,
    ST_DIV  = 5'b01000,
    ST_DONE = 5'b10000
  } state_e;

  state_e                           state_q, state_d;
  logic signed [SB-1:0]             low_q, high_q;
  logic signed [SB-1:0]             smp_q;
  logic [SB-1:0]                    diff_q, rng_q;
  logic [mmng8_pkg::GrayBits-1:0]   res_gray_q, res_gray_d;
  logic                             res_flat_q, res_flat_d;
  logic                             out_valid_q;
  mmng8_pkg::out_item_t             out_data_q;

  logic                             in_acc;
  logic                             out_free;
  logic signed [SB:0]               diff_w, rng_w;
  logic                             flat_w, neg_w, below_w, above_w;
  logic [SB+7:0]                    prod_w;
  mmng8_pkg::div_req_t              div_req;
  mmng8_pkg::div_rsp_t              div_rsp;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  assign diff_w  = {smp_q[SB-1], smp_q} - {low_q[SB-1], low_q};
  assign rng_w   = {high_q[SB-1], high_q} - {low_q[SB-1], low_q};
  assign flat_w  = (rng_w == '0);
  assign neg_w   = rng_w[SB];
  assign below_w = (smp_q <= low_q);
  assign above_w = (smp_q >= high_q);

  // x*255 as (x << 8) - x
  assign prod_w = {diff_q, 8'd0} - {8'd0, diff_q};

  always_comb begin
    div_req.start = (state_q == ST_MUL);
    // round half up: floor((2*num + d) / (2*d))
    div_req.num   = {prod_w, 1'b0} + mmng8_pkg::NumW'(rng_q);
    div_req.den   = {rng_q, 1'b0};
  end

  mmng8_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  always_comb begin
    state_d    = state_q;
    res_gray_d = res_gray_q;
    res_flat_d = res_flat_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc && in_data_i.kind == mmng8_pkg::KindNorm) begin
          state_d = ST_PREP;
        end
      end
      ST_PREP: begin
        res_flat_d = flat_w;
        priority if (flat_w || neg_w || below_w) begin
          res_gray_d = '0;
          state_d    = ST_DONE;
        end else if (above_w) begin
          res_gray_d = '1;
          state_d    = ST_DONE;
        end else begin
          state_d = ST_MUL;
        end
      end
      ST_MUL: begin
        state_d = ST_DIV;
      end
      ST_DIV: begin
        if (div_rsp.done) begin
          res_gray_d = div_rsp.quot;
          state_d    = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      low_q       <= '0;
      high_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (in_acc && in_data_i.kind == mmng8_pkg::KindScan) begin
        if (in_data_i.first) begin
          low_q  <= in_data_i.sample;
          high_q <= in_data_i.sample;
        end else begin
          if (in_data_i.sample < low_q) begin
            low_q <= in_data_i.sample;
          end
          if (in_data_i.sample > high_q) begin
            high_q <= in_data_i.sample;
          end
        end
      end
      if (state_q == ST_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    res_gray_q <= res_gray_d;
    res_flat_q <= res_flat_d;
    if (in_acc) begin
      smp_q <= in_data_i.sample;
    end
    if (state_q == ST_PREP) begin
      diff_q <= diff_w[SB-1:0];
      rng_q  <= rng_w[SB-1:0];
    end
    if (state_q == ST_DONE && out_free) begin
      out_data_q.gray <= res_gray_q;
      out_data_q.flat <= res_flat_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // running range never inverts
  a_range_order : assert property (@(posedge clk_i) disable iff (!rst_ni)
    low_q <= high_q)
    else $error("min above max");

  // a flat frame always reports black
  a_flat_gray : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.flat |-> out_data_o.gray == '0)
    else $error("flat result with nonzero gray");

  // divider finishes only while the sequencer waits on it
  a_div_done : assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> state_q == ST_DIV)
    else $error("divider done outside divide state");

  // a new result is loaded only into a free output register
  a_out_load : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DONE && out_valid_q && out_stall_i |=> state_q == ST_DONE)
    else $error("result left core while output stalled");

endmodule

`default_nettype wire

// ===== dv/min_max_normalize_to_gray8_core_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// min_max_normalize_to_gray8_core_test: self-checking bench for the gray8 core
// Runs a directed table, then random frames and noise bursts: scan bursts
// that set the min/max, followed by normalize bursts. Results are checked
// against table values or an in-bench predictor, with random input gaps and output stalls.
// ----------------------------------------------------------------------------

module min_max_normalize_to_gray8_core_test;

  localparam int GrayMax    = 255;
  localparam int ItemTarget = 2000;
  localparam int CycleLimit = 1500000;
  localparam int DrainWait  = 40;
  localparam int DirRows    = 25;

  typedef struct {
    logic kind;
    int   sample;
    logic first;
    bit   typed;
    int   gray;
    bit   flat;
  } dir_row_t;

  // typed rows carry the result read straight off the behavior; others use
  // the predictor
  dir_row_t dir_rows [DirRows] = '{
    '{mmng8_pkg::KindNorm,      0, 1'b0, 1'b1,   0, 1'b1},  // before any scan: flat
    '{mmng8_pkg::KindNorm, -32768, 1'b0, 1'b1,   0, 1'b1},
    '{mmng8_pkg::KindScan,    100, 1'b0, 1'b0,   0, 1'b0},  // no first: range 0..100
    '{mmng8_pkg::KindNorm,      0, 1'b0, 1'b1,   0, 1'b0},
    '{mmng8_pkg::KindNorm,    100, 1'b0, 1'b1, 255, 1'b0},
    '{mmng8_pkg::KindNorm,     50, 1'b0, 1'b0,   0, 1'b0},  // exact half, rounds up
    '{mmng8_pkg::KindNorm,     -5, 1'b0, 1'b1,   0, 1'b0},  // below range
    '{mmng8_pkg::KindNorm,    200, 1'b0, 1'b1, 255, 1'b0},  // above range
    '{mmng8_pkg::KindScan, -32768, 1'b1, 1'b0,   0, 1'b0},
    '{mmng8_pkg::KindNorm, -32768, 1'b0, 1'b1,   0, 1'b1},
    '{mmng8_pkg::KindNorm,  32767, 1'b0, 1'b1,   0, 1'b1},
    '{mmng8_pkg::KindScan,  32767, 1'b0, 1'b0,   0, 1'b0},  // full range
    '{mmng8_pkg::KindNorm, -32768, 1'b0, 1'b1,   0, 1'b0},
    '{mmng8_pkg::KindNorm,  32767, 1'b0, 1'b1, 255, 1'b0},
    '{mmng8_pkg::KindNorm,      0, 1'b0, 1'b0,   0, 1'b0},
    '{mmng8_pkg::KindNorm,     -1, 1'b0, 1'b0,   0, 1'b0},
    '{mmng8_pkg::KindScan,      5, 1'b1, 1'b0,   0, 1'b0},
    '{mmng8_pkg::KindScan,      6, 1'b0, 1'b0,   0, 1'b0},  // range of one
    '{mmng8_pkg::KindNorm,      5, 1'b0, 1'b1,   0, 1'b0},
    '{mmng8_pkg::KindNorm,      6, 1'b0, 1'b1, 255, 1'b0},
    '{mmng8_pkg::KindScan,      0, 1'b1, 1'b0,   0, 1'b0},
    '{mmng8_pkg::KindScan,      2, 1'b0, 1'b0,   0, 1'b0},
    '{mmng8_pkg::KindNorm,      1, 1'b1, 1'b0,   0, 1'b0},  // first ignored on normalize
    '{mmng8_pkg::KindScan,     -3, 1'b0, 1'b0,   0, 1'b0},
    '{mmng8_pkg::KindNorm,     -2, 1'b0, 1'b0,   0, 1'b0}
  };

  logic                  clk_i;
  logic                  rst_ni;
  logic                  in_valid_i;
  logic                  in_stall_o;
  mmng8_pkg::in_item_t   in_data_i;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  mmng8_pkg::out_item_t  out_data_o;

  logic signed [mmng8_pkg::SampleBits-1:0] frame_lo;
  logic signed [mmng8_pkg::SampleBits-1:0] frame_hi;
  mmng8_pkg::out_item_t                    gray_due_q [$];

  bit calm;
  int stall_run;
  int cycles;
  int errors;
  int n_items, n_scan, n_norm, n_frames, n_results, n_flat, n_clamped;

  min_max_normalize_to_gray8_core i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic mmng8_pkg::out_item_t gray_of(
    input logic signed [mmng8_pkg::SampleBits-1:0] s);
    int                   sv, lo, hi, d, num, q;
    mmng8_pkg::out_item_t r;
    sv     = s;
    lo     = frame_lo;
    hi     = frame_hi;
    d      = hi - lo;
    r.flat = (d == 0);
    r.gray = '0;
    if (d <= 0 || sv <= lo) return r;
    if (sv >= hi) begin
      r.gray = GrayMax[mmng8_pkg::GrayBits-1:0];
      return r;
    end
    num = (sv - lo) * GrayMax;
    q   = (2 * num + d) / (2 * d);
    if (q > GrayMax) q = GrayMax;
    r.gray = q[mmng8_pkg::GrayBits-1:0];
    return r;
  endfunction

  // mostly zero or short, now and then long
  function automatic int pick_gap();
    if (calm || $urandom_range(0, 2) != 0) return 0;
    if ($urandom_range(0, 15) == 0) return $urandom_range(15, 50);
    return $urandom_range(1, 3);
  endfunction

  function automatic int rand_sample();
    logic [mmng8_pkg::SampleBits-1:0] v;
    v = mmng8_pkg::SampleBits'($urandom);
    return int'($signed(v));
  endfunction

  task automatic flag_error(input string msg);
    errors++;
    if (errors <= 10) $display("ERROR @%0d: %s", cycles, msg);
  endtask

  task automatic drive_item(input logic kind, input int sample, input logic first,
                            input bit typed, input mmng8_pkg::out_item_t typed_res);
    mmng8_pkg::in_item_t  it;
    mmng8_pkg::out_item_t want;
    int                   gap;
    it.kind   = kind;
    it.sample = sample[mmng8_pkg::SampleBits-1:0];
    it.first  = first;
    gap       = pick_gap();
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    in_data_i  = it;
    do @(posedge clk_i); while (in_stall_o);
    n_items++;
    if (kind == mmng8_pkg::KindScan) begin
      n_scan++;
      if (first) begin
        frame_lo = it.sample;
        frame_hi = it.sample;
      end else begin
        if (it.sample < frame_lo) frame_lo = it.sample;
        if (it.sample > frame_hi) frame_hi = it.sample;
      end
    end else begin
      n_norm++;
      want = typed ? typed_res : gray_of(it.sample);
      if (want.flat) n_flat++;
      else if (want.gray == '0 || want.gray == GrayMax[mmng8_pkg::GrayBits-1:0])
        n_clamped++;
      gray_due_q.push_back(want);
    end
  endtask

  task automatic wait_for_results();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (gray_due_q.size() != 0) @(posedge clk_i);
  endtask

  // receiver stall: runs of random length, off while calm
  always @(negedge clk_i) begin
    if (stall_run > 0) begin
      stall_run--;
    end else begin
      out_stall_i = !calm && ($urandom_range(0, 2) == 0);
      stall_run   = ($urandom_range(0, 15) == 0) ? $urandom_range(15, 50)
                                                 : $urandom_range(0, 3);
    end
  end

  always @(posedge clk_i) begin
    mmng8_pkg::out_item_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      n_results++;
      if (gray_due_q.size() == 0) begin
        flag_error($sformatf("unexpected result gray=%0d flat=%0b",
                             out_data_o.gray, out_data_o.flat));
      end else begin
        want = gray_due_q.pop_front();
        if (want.gray !== out_data_o.gray || want.flat !== out_data_o.flat)
          flag_error($sformatf("result %0d: expected gray=%0d flat=%0b, got gray=%0d flat=%0b",
                               n_results, want.gray, want.flat,
                               out_data_o.gray, out_data_o.flat));
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CycleLimit) begin
      $display("Timeout after %0d cycles, %0d results outstanding", cycles,
               gray_due_q.size());
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    mmng8_pkg::out_item_t none;
    int                   scan_vals [$];
    int                   i, j, n, m, tmp, sel, lo, hi, span, a, b, smp;
    none       = '0;
    in_valid_i = 1'b0;
    in_data_i  = '0;
    rst_ni     = 1'b0;
    frame_lo   = '0;
    frame_hi   = '0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    for (i = 0; i < DirRows; i++) begin
      none.gray = dir_rows[i].gray[mmng8_pkg::GrayBits-1:0];
      none.flat = dir_rows[i].flat;
      drive_item(dir_rows[i].kind, dir_rows[i].sample, dir_rows[i].first,
                 dir_rows[i].typed, none);
    end
    none = '0;
    wait_for_results();

    while (n_items < ItemTarget) begin
      calm = ($urandom_range(0, 5) == 0);
      if ($urandom_range(0, 9) == 0) begin
        // noise: any kind, any flag, any value
        n = $urandom_range(1, 10);
        for (i = 0; i < n; i++)
          drive_item(1'($urandom_range(0, 1)), rand_sample(),
                     1'($urandom_range(0, 1)), 1'b0, none);
      end else begin
        n_frames++;
        sel = $urandom_range(0, 9);
        if (sel == 0) begin
          lo = rand_sample();
          hi = lo;
        end else if (sel == 1) begin
          lo = -32768;
          hi = 32767;
        end else if (sel <= 4) begin
          span = $urandom_range(1, 8);
          lo   = rand_sample();
          if (lo + span > 32767) lo = 32767 - span;
          hi   = lo + span;
        end else begin
          a  = rand_sample();
          b  = rand_sample();
          lo = (a < b) ? a : b;
          hi = (a < b) ? b : a;
        end
        // scan burst holds both ends, in shuffled order after the first
        scan_vals.delete();
        scan_vals.push_back(lo + $urandom_range(0, hi - lo));
        scan_vals.push_back(lo);
        scan_vals.push_back(hi);
        n = $urandom_range(0, 9);
        for (i = 0; i < n; i++) scan_vals.push_back(lo + $urandom_range(0, hi - lo));
        for (i = scan_vals.size() - 1; i > 1; i--) begin
          j            = $urandom_range(1, i);
          tmp          = scan_vals[i];
          scan_vals[i] = scan_vals[j];
          scan_vals[j] = tmp;
        end
        // a missing first flag now and then merges with the previous frame
        drive_item(mmng8_pkg::KindScan, scan_vals[0], $urandom_range(0, 15) != 0,
                   1'b0, none);
        for (i = 1; i < scan_vals.size(); i++)
          drive_item(mmng8_pkg::KindScan, scan_vals[i], 1'b0, 1'b0, none);
        m = $urandom_range(1, 12);
        for (i = 0; i < m; i++) begin
          smp = ($urandom_range(0, 19) < 17) ? lo + $urandom_range(0, hi - lo)
                                             : rand_sample();
          drive_item(mmng8_pkg::KindNorm, smp, 1'($urandom_range(0, 1)), 1'b0, none);
        end
      end
      if ($urandom_range(0, 9) == 0) wait_for_results();
    end

    calm = 1'b0;
    wait_for_results();
    repeat (DrainWait) @(posedge clk_i);
    if (gray_due_q.size() != 0)
      flag_error($sformatf("%0d results never arrived", gray_due_q.size()));

    $display("Run: %0d items (%0d scan, %0d normalize) over %0d frames plus noise bursts.",
             n_items, n_scan, n_norm, n_frames);
    $display("Checked %0d results: %0d flat, %0d at a range end; %0d errors.",
             n_results, n_flat, n_clamped, errors);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
